FILE: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_TAB       = 8'd9;
  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_RETURN    = 8'd13;
  localparam logic [7:0]  CH_SPACE     = 8'd32;
  localparam logic [15:0] RESET_CELL   = 16'h0720;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;

  // register index, taken from paddr[2]
  localparam logic [0:0]  REG_TEXT_COLOR = 1'b0;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_entry;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_TAB
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_EXEC,
    ST_READ_WAIT,
    ST_BLANK,
    ST_OUT
  } state_t;

endpackage

FILE: sv/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: character-cell screen store with cursor, control codes,
// line wrap and scroll; read transactions return one cell.
// ----------------------------------------------------------------------------
// channel   | handshake                  | payload
// req       | req_valid / req_stall      | req   (mode, char_code, read_row, read_column)
// rsp       | rsp_valid / rsp_stall      | rsp   (cell_entry, cursor_row, cursor_column)
// config    | psel penable pwrite pready | paddr, pwdata, prdata (text_color)
//
// Write transaction: EXEC then OUT in the back end, with a BLANK sweep between
// when it scrolls (one blanking write per cell of the new last row, single RAM
// port). Read transaction: EXEC, READ_WAIT (registered RAM read), OUT; no
// READ_WAIT when out of range. After reset a clear pass fills every cell; req
// is stalled meanwhile. A two-entry queue accepts up to two req while rsp is stalled.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]   text_color;
  head_t        head;
  logic         pop;
  back_status_t status;
  logic         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == REG_TEXT_COLOR);
  assign prdata  = reg_sel ? {24'h000000, text_color} : 32'h00000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      text_color <= pwdata[7:0];
    end
  end

  tcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (status.clearing),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .pop      (pop),
    .head     (head)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .text_color(text_color),
    .head      (head),
    .pop       (pop),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !rsp_valid && !pop)
    else $error("response or dequeue during clear pass");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.cursor_row) < ROWS)
    else $error("cursor row out of range");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.cursor_column) < COLUMNS)
    else $error("cursor column out of range");

endmodule

FILE: sv/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request transactions, decodes them into commands and queues them
// in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  hold,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  input  logic  pop,
  output head_t head
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop_ok;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.char_code   = req.char_code;
    cmd_in.read_row    = req.read_row;
    cmd_in.read_column = req.read_column;
    if (req.mode) begin
      cmd_in.op = OP_READ;
    end else begin
      case (req.char_code)
        CH_NEWLINE:   cmd_in.op = OP_NEWLINE;
        CH_RETURN:    cmd_in.op = OP_RETURN;
        CH_BACKSPACE: cmd_in.op = OP_BACKSPACE;
        CH_TAB:       cmd_in.op = OP_TAB;
        default:      cmd_in.op = OP_PUT;
      endcase
    end
  end

  assign req_stall  = hold || (count == 2'd2);
  assign push       = req_valid && !req_stall;
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slot[rd_ptr];
  assign pop_ok     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

endmodule

FILE: sv/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued commands: cursor update, screen store access, scroll by
// a rotating top-row pointer with a row blanking sweep, and the clear pass.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   text_color,
  input  head_t        head,
  output logic         pop,
  output back_status_t status,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output rsp_t         rsp
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  state_t           state;
  state_t           state_next;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] top;
  logic [AW-1:0]    sweep;
  logic [15:0]      res_cell;

  logic [COL_W:0]   col_calc;
  logic [ROW_W:0]   row_calc;
  logic             row_inc;
  logic             scroll;
  logic             put_en;
  logic [7:0]       put_char;
  logic [COL_W-1:0] put_col;
  logic             rd_ok;
  logic             is_read;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [15:0]      ram_wdata;
  logic [15:0]      ram_rdata;

  function automatic logic [AW-1:0] cell_addr(
    input logic [ROW_W-1:0] lrow,
    input logic [COL_W-1:0] c,
    input logic [ROW_W-1:0] t
  );
    logic [ROW_W:0] p;
    p = {1'b0, lrow} + {1'b0, t};
    if (p >= (ROW_W+1)'(ROWS)) begin
      p = p - (ROW_W+1)'(ROWS);
    end
    return AW'(p) * AW'(COLUMNS) + AW'(c);
  endfunction

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign is_read = (head.cmd.op == OP_READ);
  assign rd_ok   = (32'(head.cmd.read_row) < ROWS) && (32'(head.cmd.read_column) < COLUMNS);

  // cursor arithmetic for a write command
  always_comb begin
    col_calc = {1'b0, col};
    row_inc  = 1'b0;
    put_en   = 1'b0;
    put_char = CH_SPACE;
    put_col  = col;
    case (head.cmd.op)
      OP_NEWLINE: begin
        col_calc = '0;
        row_inc  = 1'b1;
      end
      OP_RETURN: begin
        col_calc = '0;
      end
      OP_BACKSPACE: begin
        if (col != '0) begin
          col_calc = {1'b0, col} - (COL_W+1)'(1);
        end
        put_en  = 1'b1;
        put_col = col_calc[COL_W-1:0];
      end
      OP_TAB: begin
        col_calc = {({1'b0, col[COL_W-1:2]} + (COL_W-1)'(1)), 2'b00};
      end
      OP_PUT: begin
        put_en   = 1'b1;
        put_char = head.cmd.char_code;
        col_calc = {1'b0, col} + (COL_W+1)'(1);
      end
      default: begin
        col_calc = {1'b0, col};
      end
    endcase
    if (col_calc >= (COL_W+1)'(COLUMNS)) begin
      col_calc = col_calc - (COL_W+1)'(COLUMNS);
      row_inc  = 1'b1;
    end
    row_calc = {1'b0, row} + (ROW_W+1)'(row_inc);
    scroll   = (row_calc == (ROW_W+1)'(ROWS));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sweep == AW'(DEPTH - 1)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (head.valid) begin
          if (is_read) begin
            state_next = rd_ok ? ST_READ_WAIT : ST_OUT;
          end else begin
            state_next = scroll ? ST_BLANK : ST_OUT;
          end
        end
      end
      ST_READ_WAIT: state_next = ST_OUT;
      ST_BLANK: begin
        if (sweep == AW'(COLUMNS - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rsp_stall) begin
          state_next = ST_EXEC;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we          = 1'b0;
    ram_addr        = '0;
    ram_wdata       = {text_color, CH_SPACE};
    pop             = 1'b0;
    rsp_valid       = 1'b0;
    status.clearing = 1'b0;
    case (state)
      ST_CLEAR: begin
        status.clearing = 1'b1;
        ram_we          = 1'b1;
        ram_addr        = sweep;
        ram_wdata       = RESET_CELL;
      end
      ST_EXEC: begin
        pop = head.valid;
        if (is_read) begin
          ram_addr = cell_addr(ROW_W'(head.cmd.read_row), COL_W'(head.cmd.read_column), top);
        end else begin
          ram_we    = head.valid && put_en;
          ram_addr  = cell_addr(row, put_col, top);
          ram_wdata = {text_color, put_char};
        end
      end
      ST_BLANK: begin
        ram_we   = 1'b1;
        ram_addr = cell_addr(ROW_W'(ROWS - 1), sweep[COL_W-1:0], top);
      end
      ST_OUT: rsp_valid = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      row   <= '0;
      col   <= '0;
      top   <= '0;
      sweep <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: begin
          sweep <= (sweep == AW'(DEPTH - 1)) ? '0 : sweep + AW'(1);
        end
        ST_EXEC: begin
          sweep <= '0;
          if (head.valid && !is_read) begin
            col <= col_calc[COL_W-1:0];
            if (scroll) begin
              row <= ROW_W'(ROWS - 1);
              top <= (top == ROW_W'(ROWS - 1)) ? '0 : top + ROW_W'(1);
            end else begin
              row <= row_calc[ROW_W-1:0];
            end
          end
        end
        ST_BLANK: sweep <= sweep + AW'(1);
        default: sweep <= sweep;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && head.valid) begin
      res_cell <= 16'h0000;
    end else if (state == ST_READ_WAIT) begin
      res_cell <= ram_rdata;
    end
  end

  assign rsp.cell_entry    = res_cell;
  assign rsp.cursor_row    = 5'(row);
  assign rsp.cursor_column = 7'(col);

endmodule
